/* sv/cfr_pkg.sv */
`default_nettype none

package cfr_pkg;

    // Frame layout
    localparam int FRAME_LEN = 11;
    localparam int CRC_LEN   = 10;
    localparam int CNT_W     = 4;

    localparam logic [7:0]  HDR_A       = 8'hAA;
    localparam logic [7:0]  HDR_B       = 8'h55;
    localparam logic [7:0]  CRC_POLY    = 8'h07;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    // Register reset values
    localparam logic [15:0] TIMEOUT_RST = 16'd500;
    localparam logic [14:0] LIMIT_RST   = 15'd1000;
    localparam logic [7:0]  VERSION_RST = 8'h01;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int OUT_W  = 40;

    typedef enum logic [1:0] {
        REG_TIMEOUT = 2'd0,
        REG_LIMIT   = 2'd1,
        REG_VERSION = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] link_timeout_ms;
        logic [14:0] input_limit;
        logic [7:0]  protocol_version;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic crc_step;
        logic check;
        logic shift;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic completes;
        logic crc_last;
        logic need_shift;
        logic shift_last;
        logic out_free;
    } stat_t;

    // One byte through the CRC-8 register, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] d);
        logic [7:0] c;
        c = c_in ^ d;
        for (int b = 0; b < 8; b++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Saturate a big-endian signed word to +/- lim
    function automatic logic [15:0] clamp_word(input logic [7:0] hi, input logic [7:0] lo,
                                               input logic [14:0] lim);
        logic signed [16:0] v;
        logic signed [16:0] l;
        logic signed [16:0] nl;
        logic [15:0]        r;
        v  = $signed({hi[7], hi, lo});
        l  = $signed({2'b00, lim});
        nl = -l;
        if (v > l)
            r = l[15:0];
        else if (v < nl)
            r = nl[15:0];
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/cfr_ctrl.sv */
`default_nettype none

module cfr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire cfr_pkg::stat_t stat,
    output cfr_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_CRC,
        ST_CHECK,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                    state_next = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = stat.completes ? ST_CRC : ST_FINISH;
            end
            ST_CRC:
            begin
                cmd.crc_step = 1'b1;
                if (stat.crc_last)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.need_shift ? ST_SHIFT : ST_FINISH;
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.shift_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = stat.out_free;
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* sv/cfr_dpath.sv */
`default_nettype none

module cfr_dpath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cfr_pkg::cfg_t               cfg,
    input  wire cfr_pkg::cmd_t               cmd,
    output cfr_pkg::stat_t                   stat,
    input  wire logic                        in_op,
    input  wire logic [7:0]                  in_byte,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [cfr_pkg::OUT_W-1:0]        out_data
);

    // Item and frame store (payload, no reset)
    logic                          op_reg,   op_next;
    logic [7:0]                    byte_reg, byte_next;
    logic [7:0]                    store_reg  [cfr_pkg::FRAME_LEN];
    logic [7:0]                    store_next [cfr_pkg::FRAME_LEN];
    logic [7:0]                    crc_reg,  crc_next;
    logic [cfr_pkg::OUT_W-1:0]     out_data_reg, out_data_next;

    // Control state
    logic [cfr_pkg::CNT_W-1:0]     count_reg,     count_next;
    logic [cfr_pkg::CNT_W-1:0]     crc_idx_reg,   crc_idx_next;
    logic [cfr_pkg::CNT_W-1:0]     shift_cnt_reg, shift_cnt_next;
    logic [15:0]                   thr_reg,       thr_next;
    logic [15:0]                   steer_reg,     steer_next;
    logic                          mode_reg,      mode_next;
    logic                          enable_reg,    enable_next;
    logic                          conn_reg,      conn_next;
    logic                          seen_reg,      seen_next;
    logic [15:0]                   elapsed_reg,   elapsed_next;
    logic                          res_ok_reg,    res_ok_next;
    logic                          res_crc_reg,   res_crc_next;
    logic                          out_valid_reg, out_valid_next;

    logic [cfr_pkg::FRAME_LEN-2:1] pair_hit;
    logic                          pair_any;
    logic [cfr_pkg::CNT_W-1:0]     first_s;
    logic                          crc_bad;
    logic                          frame_good;
    logic                          disc;
    logic                          changed;

    // Embedded header pairs at positions 1..9, lowest position wins
    always_comb
    begin
        pair_any = 1'b0;
        first_s  = '0;
        for (int s = 1; s <= cfr_pkg::FRAME_LEN - 2; s++)
            pair_hit[s] = (store_reg[s] == cfr_pkg::HDR_A) && (store_reg[s+1] == cfr_pkg::HDR_B);
        for (int s = cfr_pkg::FRAME_LEN - 2; s >= 1; s--)
        begin
            if (pair_hit[s])
            begin
                pair_any = 1'b1;
                first_s  = cfr_pkg::CNT_W'(s);
            end
        end
    end

    assign crc_bad    = (crc_reg != store_reg[cfr_pkg::FRAME_LEN-1]);
    assign frame_good = !crc_bad
                        && (store_reg[2] == cfg.protocol_version)
                        && (store_reg[3] <= 8'd1)
                        && (store_reg[4] <= 8'd1);
    assign disc       = !seen_reg || (elapsed_reg > cfg.link_timeout_ms);
    assign changed    = res_ok_reg || (disc && conn_reg);

    always_comb
    begin
        op_next        = op_reg;
        byte_next      = byte_reg;
        store_next     = store_reg;
        crc_next       = crc_reg;
        out_data_next  = out_data_reg;
        count_next     = count_reg;
        crc_idx_next   = crc_idx_reg;
        shift_cnt_next = shift_cnt_reg;
        thr_next       = thr_reg;
        steer_next     = steer_reg;
        mode_next      = mode_reg;
        enable_next    = enable_reg;
        conn_next      = conn_reg;
        seen_next      = seen_reg;
        elapsed_next   = elapsed_reg;
        res_ok_next    = res_ok_reg;
        res_crc_next   = res_crc_reg;
        out_valid_next = out_valid_reg;

        if (out_ready)
            out_valid_next = 1'b0;

        if (cmd.load)
        begin
            op_next      = in_op;
            byte_next    = in_byte;
            res_ok_next  = 1'b0;
            res_crc_next = 1'b0;
        end

        if (cmd.step)
        begin
            crc_next     = '0;
            crc_idx_next = '0;
            if (op_reg)
            begin
                if (elapsed_reg != cfr_pkg::ELAPSED_MAX)
                    elapsed_next = elapsed_reg + 16'd1;
            end
            else if (count_reg == '0)
            begin
                if (byte_reg == cfr_pkg::HDR_A)
                begin
                    store_next[0] = byte_reg;
                    count_next    = cfr_pkg::CNT_W'(1);
                end
            end
            else if (count_reg == cfr_pkg::CNT_W'(1))
            begin
                if (byte_reg == cfr_pkg::HDR_B)
                begin
                    store_next[1] = byte_reg;
                    count_next    = cfr_pkg::CNT_W'(2);
                end
                else if (byte_reg != cfr_pkg::HDR_A)
                begin
                    count_next = '0;
                end
            end
            else if (count_reg >= cfr_pkg::CNT_W'(cfr_pkg::FRAME_LEN))
            begin
                count_next = '0;
            end
            else
            begin
                store_next[count_reg] = byte_reg;
                count_next            = count_reg + cfr_pkg::CNT_W'(1);
            end
        end

        if (cmd.crc_step)
        begin
            crc_next     = cfr_pkg::crc8_byte(crc_reg, store_reg[crc_idx_reg]);
            crc_idx_next = crc_idx_reg + cfr_pkg::CNT_W'(1);
        end

        if (cmd.check)
        begin
            res_crc_next = crc_bad;
            if (frame_good)
            begin
                enable_next  = store_reg[3][0];
                mode_next    = store_reg[4][0];
                thr_next     = cfr_pkg::clamp_word(store_reg[5], store_reg[6], cfg.input_limit);
                steer_next   = cfr_pkg::clamp_word(store_reg[7], store_reg[8], cfg.input_limit);
                conn_next    = 1'b1;
                seen_next    = 1'b1;
                elapsed_next = '0;
                count_next   = '0;
                res_ok_next  = 1'b1;
            end
            else if (pair_any)
            begin
                count_next     = cfr_pkg::CNT_W'(cfr_pkg::FRAME_LEN) - first_s;
                shift_cnt_next = first_s;
            end
            else if (store_reg[cfr_pkg::FRAME_LEN-1] == cfr_pkg::HDR_A)
            begin
                store_next[0] = cfr_pkg::HDR_A;
                count_next    = cfr_pkg::CNT_W'(1);
            end
            else
            begin
                count_next = '0;
            end
        end

        // Slide the store down one byte toward the found header
        if (cmd.shift)
        begin
            for (int k = 0; k < cfr_pkg::FRAME_LEN - 1; k++)
                store_next[k] = store_reg[k+1];
            shift_cnt_next = shift_cnt_reg - cfr_pkg::CNT_W'(1);
        end

        if (cmd.finish)
        begin
            if (disc)
            begin
                seen_next   = 1'b0;
                conn_next   = 1'b0;
                thr_next    = '0;
                steer_next  = '0;
                mode_next   = 1'b0;
                enable_next = 1'b0;
            end
            out_data_next  = {2'b00, conn_next, enable_next, mode_next, steer_next, thr_next,
                              changed, res_crc_reg, res_ok_reg};
            out_valid_next = 1'b1;
        end
    end

    assign stat.completes  = !op_reg && (count_reg == cfr_pkg::CNT_W'(cfr_pkg::FRAME_LEN - 1));
    assign stat.crc_last   = (crc_idx_reg == cfr_pkg::CNT_W'(cfr_pkg::CRC_LEN - 1));
    assign stat.need_shift = !frame_good && pair_any;
    assign stat.shift_last = (shift_cnt_reg == cfr_pkg::CNT_W'(1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        byte_reg     <= byte_next;
        store_reg    <= store_next;
        crc_reg      <= crc_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            crc_idx_reg   <= '0;
            shift_cnt_reg <= '0;
            thr_reg       <= '0;
            steer_reg     <= '0;
            mode_reg      <= 1'b0;
            enable_reg    <= 1'b0;
            conn_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            elapsed_reg   <= '0;
            res_ok_reg    <= 1'b0;
            res_crc_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            crc_idx_reg   <= crc_idx_next;
            shift_cnt_reg <= shift_cnt_next;
            thr_reg       <= thr_next;
            steer_reg     <= steer_next;
            mode_reg      <= mode_next;
            enable_reg    <= enable_next;
            conn_reg      <= conn_next;
            seen_reg      <= seen_next;
            elapsed_reg   <= elapsed_next;
            res_ok_reg    <= res_ok_next;
            res_crc_reg   <= res_crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* sv/crc8_command_frame_receiver.sv */
`default_nettype none

// Channel   Direction  Transaction carries
// s_*       in         one received byte or one millisecond tick
// m_*       out        one status/command word per input transaction
// APB       in/out     link_timeout_ms (0x0), input_limit (0x4), protocol_version (0x8)
//
// A tick or a byte that does not close a frame holds the block through accept, step and
// emit; its result is registered at emit. The closing byte of a frame holds it through accept,
// step, the CRC-8 walk over the ten covered bytes one per cycle, a check step and, for a rejected
// frame with an embedded header at position s, a slide of the store down one byte per cycle
// (s from 1 to 9, else 0) before emit. No new item is taken until the block is idle again.
// Reset clears control state only; the frame store is never cleared, since only
// written entries are read. A stalled result holds the next result in its final step.

module crc8_command_frame_receiver (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // stream in
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] rx_byte
    input  wire logic                        s_tuser,   // [0] op (0 byte, 1 tick)
    // stream out
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [0] frame_ok, [1] crc_error, [2] command_changed, [18:3] throttle,
    // [34:19] steering, [35] drive_mode, [36] drive_enable, [37] link_up, [39:38] zero
    output logic [cfr_pkg::OUT_W-1:0]        m_tdata,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cfr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [cfr_pkg::DATA_W-1:0]  pwdata,
    output logic [cfr_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);

    cfr_pkg::cfg_t  cfg_reg;
    cfr_pkg::cfg_t  cfg_next;
    cfr_pkg::cmd_t  cmd;
    cfr_pkg::stat_t stat;
    logic           cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Register write: data is masked to each register's width; unmapped slots drop the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfr_pkg::reg_idx_t'(paddr[3:2]))
                cfr_pkg::REG_TIMEOUT: cfg_next.link_timeout_ms  = pwdata[15:0];
                cfr_pkg::REG_LIMIT:   cfg_next.input_limit      = pwdata[14:0];
                cfr_pkg::REG_VERSION: cfg_next.protocol_version = pwdata[7:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfr_pkg::reg_idx_t'(paddr[3:2]))
            cfr_pkg::REG_TIMEOUT: prdata = {16'd0, cfg_reg.link_timeout_ms};
            cfr_pkg::REG_LIMIT:   prdata = {17'd0, cfg_reg.input_limit};
            cfr_pkg::REG_VERSION: prdata = {24'd0, cfg_reg.protocol_version};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_timeout_ms  <= cfr_pkg::TIMEOUT_RST;
            cfg_reg.input_limit      <= cfr_pkg::LIMIT_RST;
            cfg_reg.protocol_version <= cfr_pkg::VERSION_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: accept, step, CRC walk, check, resync slide, emit
    cfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Frame store, CRC, held command, watchdog and output register
    cfr_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (s_tuser),
        .in_byte   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // An accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in consecutive cycles");

    // A frame cannot be both accepted and a CRC failure
    a_ok_xor_crc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("frame_ok and crc_error both set");

    // An accepted frame brings the link up and advances the command
    a_ok_link: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[2] && m_tdata[37]))
        else $error("accepted frame without link_up or command_changed");

    // A dead link carries a cleared command
    a_down_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[37]) |-> (m_tdata[36:3] == '0))
        else $error("command not cleared while link is down");

endmodule

`default_nettype wire
